>>> design/rpi_pkg.sv
// Shared types, constants and helpers for the ray/primitive intersection pipeline.
// No dependencies; imported by every module of the block but rpi_delay.
package rpi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_T_MIN     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_EPS = 4'd1;
    localparam logic [30:0] T_MIN_RST     = 31'd7;
    localparam logic [15:0] DENOM_EPS_RST = 16'd1;

    localparam logic SHAPE_SPHERE = 1'b0;
    localparam logic SHAPE_PLANE  = 1'b1;

    // pipelined units
    localparam int SQRT_LAT = 16;       // two root bits per stage
    localparam int Q_W      = 31;       // quotient bits, plus one overflow stage
    localparam int DIV_LAT  = Q_W + 1;

    localparam int SAT_W = 80;          // working width ahead of a 32-bit clamp

    typedef struct packed {
        logic               shape_kind;
        logic signed [31:0] prim_x;
        logic signed [31:0] prim_y;
        logic signed [31:0] prim_z;
        logic signed [31:0] prim_scalar;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic        [30:0] t_max;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic        [30:0] distance;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]))
            r = v[31:0];
        else
            r = v[SAT_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        return r;
    endfunction

    // sign/magnitude quotient to clamped two's complement
    function automatic logic signed [31:0] sat_quot(input logic neg, input logic ovf,
                                                    input logic [Q_W-1:0] q);
        logic signed [31:0] r;
        if (ovf)
            r = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            r = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return r;
    endfunction

endpackage

>>> design/rpi_delay.sv
// Enabled shift line that carries side data alongside a pipelined unit.
// Depends on nothing but its parameters.
module rpi_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         adv,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++)
                tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[N-1];

endmodule

>>> design/rpi_sqrt.sv
// Pipelined integer square root of a 64-bit value, floor result, two bits per stage.
// Uses rpi_pkg for the stage count.
module rpi_sqrt import rpi_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [63:0] in_v,
    output logic        out_valid,
    output logic [31:0] out_root
);

    logic        vld_reg  [SQRT_LAT];
    logic [31:0] root_reg [SQRT_LAT];
    logic [35:0] rem_reg  [SQRT_LAT-1];
    logic [63:0] val_reg  [SQRT_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQRT_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < SQRT_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    for (genvar s = 0; s < SQRT_LAT; s++)
    begin : g_stage
        logic [35:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] val_in;
        logic [35:0] rem_next;
        logic [31:0] root_next;
        logic [63:0] val_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = in_v;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign val_in  = val_reg[s-1];
        end

        always_comb
        begin
            logic [35:0] r;
            logic [35:0] tr;
            logic [31:0] q;
            logic [63:0] v;
            r = rem_in;
            q = root_in;
            v = val_in;
            for (int i = 0; i < 2; i++)
            begin
                r  = {r[33:0], v[63:62]};
                v  = {v[61:0], 2'b00};
                tr = {2'b00, q, 2'b01};
                if (r >= tr)
                begin
                    r = r - tr;
                    q = {q[30:0], 1'b1};
                end
                else
                    q = {q[30:0], 1'b0};
            end
            rem_next  = r;
            root_next = q;
            val_next  = v;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                root_reg[s] <= root_next;
        end

        if (s < SQRT_LAT - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s] <= rem_next;
                    val_reg[s] <= val_next;
                end
            end
        end
    end

    assign out_valid = vld_reg[SQRT_LAT-1];
    assign out_root  = root_reg[SQRT_LAT-1];

endmodule

>>> design/rpi_divider.sv
// Pipelined restoring divider on magnitudes: one quotient bit per stage, overflow flagged.
// Uses rpi_pkg for the quotient width.
module rpi_divider import rpi_pkg::*; #(
    parameter int NW = 51,
    parameter int DW = 50
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  logic           in_neg,
    input  logic [NW-1:0]  in_n,
    input  logic [DW-1:0]  in_d,
    output logic           out_valid,
    output logic           out_neg,
    output logic           out_ovf,
    output logic [Q_W-1:0] out_q
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic           vld_reg [DIV_LAT];
    logic           neg_reg [DIV_LAT];
    logic           ovf_reg [DIV_LAT];
    logic [Q_W-1:0] q_reg   [DIV_LAT];
    logic [NW-1:0]  rem_reg [DIV_LAT-1];
    logic [DW-1:0]  d_reg   [DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DIV_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 0: quotient of 2^Q_W or more saturates
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= in_n;
            d_reg[0]   <= in_d;
            neg_reg[0] <= in_neg;
            ovf_reg[0] <= CW'(in_n >> Q_W) >= CW'(in_d);
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 1; s < DIV_LAT; s++)
    begin : g_stage
        localparam int K = Q_W - s;
        logic          take;
        logic [NW-1:0] rem_next;

        assign take     = CW'(rem_reg[s-1] >> K) >= CW'(d_reg[s-1]);
        assign rem_next = take ? rem_reg[s-1] - (NW'(d_reg[s-1]) << K) : rem_reg[s-1];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                q_reg[s]   <= q_reg[s-1] | (take ? (Q_W'(1) << K) : '0);
            end
        end

        if (s < DIV_LAT - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s] <= rem_next;
                    d_reg[s]   <= d_reg[s-1];
                end
            end
        end
    end

    // a zero quotient carries no sign
    assign out_valid = vld_reg[DIV_LAT-1];
    assign out_ovf   = ovf_reg[DIV_LAT-1];
    assign out_q     = q_reg[DIV_LAT-1];
    assign out_neg   = neg_reg[DIV_LAT-1] && (ovf_reg[DIV_LAT-1] || (|q_reg[DIV_LAT-1]));

endmodule

>>> design/rpi_front.sv
// Front end: offset vector, dot products, quadratic terms and discriminant in five stages.
// Uses rpi_pkg for the item type and saturation helper.
module rpi_front import rpi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  in_item_t                  in_item,
    input  logic [15:0]               denom_eps,
    output logic                      out_valid,
    output in_item_t                  out_item,
    output logic                      out_miss,
    output logic signed [31:0]        out_hb,
    output logic signed [31:0]        out_a,
    output logic signed [31:0]        out_num,
    output logic signed [65-FRAC_BITS:0] out_den,
    output logic [63:0]               out_disc
);

    localparam int PW = 64 - FRAC_BITS;
    localparam int SW = PW + 2;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    in_item_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg;

    // stage 1: oc = origin - center for a sphere, the plane normal otherwise
    logic signed [31:0] vec_next [3];
    logic signed [31:0] vec_reg  [3];

    always_comb
    begin
        logic plane;
        plane = in_item.shape_kind == SHAPE_PLANE;
        vec_next[0] = plane ? in_item.prim_x
                            : sat32(SAT_W'(in_item.origin_x) - SAT_W'(in_item.prim_x));
        vec_next[1] = plane ? in_item.prim_y
                            : sat32(SAT_W'(in_item.origin_y) - SAT_W'(in_item.prim_y));
        vec_next[2] = plane ? in_item.prim_z
                            : sat32(SAT_W'(in_item.origin_z) - SAT_W'(in_item.prim_z));
    end

    // stage 2: floored products
    logic signed [63:0] m_dd [3];
    logic signed [63:0] m_dv [3];
    logic signed [63:0] m_vv [3];
    logic signed [63:0] m_rr;
    logic signed [PW-1:0] dd_reg [3];
    logic signed [PW-1:0] dv_reg [3];
    logic signed [PW-1:0] vv_reg [3];
    logic signed [PW-1:0] rr_reg;

    always_comb
    begin
        logic signed [31:0] d [3];
        logic signed [31:0] o [3];
        logic signed [31:0] p [3];
        d[0] = it1_reg.dir_x;    d[1] = it1_reg.dir_y;    d[2] = it1_reg.dir_z;
        o[0] = it1_reg.origin_x; o[1] = it1_reg.origin_y; o[2] = it1_reg.origin_z;
        p[0] = it1_reg.prim_x;   p[1] = it1_reg.prim_y;   p[2] = it1_reg.prim_z;
        for (int i = 0; i < 3; i++)
        begin
            m_dd[i] = 64'(d[i]) * 64'(d[i]);
            m_dv[i] = 64'(d[i]) * 64'(vec_reg[i]);
            m_vv[i] = (it1_reg.shape_kind == SHAPE_PLANE) ? 64'(o[i]) * 64'(p[i])
                                                          : 64'(vec_reg[i]) * 64'(vec_reg[i]);
        end
        m_rr = 64'(it1_reg.prim_scalar) * 64'(it1_reg.prim_scalar);
    end

    // stage 3: sums
    logic signed [SW-1:0] sum_dd, sum_dv, sum_vv;
    logic signed [31:0] a_reg, hb_reg, c_reg, num_reg;
    logic signed [SW-1:0] den_reg;

    assign sum_dd = SW'(dd_reg[0]) + SW'(dd_reg[1]) + SW'(dd_reg[2]);
    assign sum_dv = SW'(dv_reg[0]) + SW'(dv_reg[1]) + SW'(dv_reg[2]);
    assign sum_vv = SW'(vv_reg[0]) + SW'(vv_reg[1]) + SW'(vv_reg[2]);

    // stage 4: squares and early misses
    logic signed [SW-1:0] aden;
    logic                 den_small;
    logic                 miss4_next;
    logic signed [63:0]   hh_reg, ac_reg;
    logic signed [31:0]   a4_reg, hb4_reg, num4_reg;
    logic signed [SW-1:0] den4_reg;
    logic                 miss4_reg;

    assign aden      = den_reg[SW-1] ? -den_reg : den_reg;
    assign den_small = $unsigned(aden) < SW'(denom_eps);

    always_comb
    begin
        if (it3_reg.shape_kind == SHAPE_PLANE)
            miss4_next = (den_reg == '0) || den_small;
        else
            miss4_next = (it3_reg.prim_scalar == 32'sd0) || (a_reg <= 32'sd0);
    end

    // stage 5: discriminant
    logic signed [64:0] disc;
    assign disc = 65'(hh_reg) - 65'(ac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg <= in_item;
            for (int i = 0; i < 3; i++)
                vec_reg[i] <= vec_next[i];

            it2_reg <= it1_reg;
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= m_dd[i][63:FRAC_BITS];
                dv_reg[i] <= m_dv[i][63:FRAC_BITS];
                vv_reg[i] <= m_vv[i][63:FRAC_BITS];
            end
            rr_reg <= m_rr[63:FRAC_BITS];

            it3_reg <= it2_reg;
            a_reg   <= sat32(SAT_W'(sum_dd));
            hb_reg  <= sat32(SAT_W'(sum_dv));
            c_reg   <= sat32(SAT_W'(sum_vv) - SAT_W'(rr_reg));
            num_reg <= sat32(SAT_W'(it2_reg.prim_scalar) - SAT_W'(sum_vv));
            den_reg <= sum_dv;

            it4_reg   <= it3_reg;
            hh_reg    <= 64'(hb_reg) * 64'(hb_reg);
            ac_reg    <= 64'(a_reg) * 64'(c_reg);
            a4_reg    <= a_reg;
            hb4_reg   <= hb_reg;
            num4_reg  <= num_reg;
            den4_reg  <= den_reg;
            miss4_reg <= miss4_next;

            it5_reg  <= it4_reg;
            out_miss <= miss4_reg || ((it4_reg.shape_kind == SHAPE_SPHERE) && disc[64]);
            out_disc <= disc[63:0];
            out_a    <= a4_reg;
            out_hb   <= hb4_reg;
            out_num  <= num4_reg;
            out_den  <= den4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = it5_reg;

endmodule

>>> design/ray_primitive_intersect.sv
// Ray against sphere or plane intersection pipeline, top level.
// Uses rpi_pkg, rpi_front, rpi_sqrt, rpi_divider and rpi_delay.
//
// Usage:
//   in_*   : one ray/primitive test per transfer (valid/ready), payload in_item_t.
//   out_*  : one result per test, in order (valid/ready), payload out_item_t.
//            A miss returns hit = 0 with every other field zero.
//   cfg_*  : register writes; index 0 is t_min, index 1 is denom_epsilon, other
//            indexes are ignored. cfg_ready is always high. Write only while idle.
// Throughput: one test per cycle while the pipeline is not stalled.
// Pipeline: from input transfer to out_valid the chain is a 5-stage
//   front end, a 16-stage square root, the divider operand register, a 32-stage
//   divider for the distance, 4 stages for the hit point, a 32-stage divider for
//   the sphere normal, the result assembly register and the output register.
// Stall: the whole pipeline holds while the skid entry behind the output
//   register is occupied; in_ready stays high while a result waits in the
//   output register alone. Nothing is dropped or repeated.
// Reset: clears all valid bits and loads t_min = 7, denom_epsilon = 1.
module ray_primitive_intersect import rpi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int PW  = 64 - FRAC_BITS;
    localparam int DEN_W = 66 - FRAC_BITS;
    localparam int TNW = 35 + FRAC_BITS;    // distance dividend magnitude
    localparam int NNW = 33 + FRAC_BITS;    // normal dividend magnitude
    localparam int SA_W = $bits(in_item_t) + 1 + 96 + DEN_W;
    localparam int SB_W = $bits(in_item_t) + 1;
    localparam int SC_W = $bits(in_item_t) + 1 + Q_W + 96;

    // configuration
    logic [30:0] t_min_reg;
    logic [15:0] denom_eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_min_reg     <= T_MIN_RST;
            denom_eps_reg <= DENOM_EPS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_T_MIN:     t_min_reg     <= cfg_data[30:0];
                REG_DENOM_EPS: denom_eps_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    logic adv;
    logic skid_valid_reg;
    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    // front end
    logic                    f_valid, f_miss;
    in_item_t                f_item;
    logic signed [31:0]      f_hb, f_a, f_num;
    logic signed [DEN_W-1:0] f_den;
    logic [63:0]             f_disc;

    rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_item   (in_data),
        .denom_eps (denom_eps_reg),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_miss  (f_miss),
        .out_hb    (f_hb),
        .out_a     (f_a),
        .out_num   (f_num),
        .out_den   (f_den),
        .out_disc  (f_disc)
    );

    // square root with side data
    logic        sq_valid;
    logic [31:0] sq_root;

    rpi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_v      (f_disc),
        .out_valid (sq_valid),
        .out_root  (sq_root)
    );

    logic [SA_W-1:0]         sa_in, sa_out;
    in_item_t                sa_item;
    logic                    sa_miss;
    logic signed [31:0]      sa_hb, sa_a, sa_num;
    logic signed [DEN_W-1:0] sa_den;

    assign sa_in = {f_item, f_miss, f_hb, f_a, f_num, f_den};
    assign {sa_item, sa_miss, sa_hb, sa_a, sa_num, sa_den} = sa_out;

    rpi_delay #(.W(SA_W), .N(SQRT_LAT)) u_dly_a (
        .clk  (clk),
        .adv  (adv),
        .din  (sa_in),
        .dout (sa_out)
    );

    // divider operands: near root or plane quotient on unit 0, far root on unit 1
    logic signed [34:0]      near_n, far_n, n0;
    logic signed [DEN_W-1:0] d0, a_ext;
    logic [34:0]             abs_n0, abs_far;
    logic [DEN_W-1:0]        abs_d0, abs_a;

    always_comb
    begin
        near_n  = -35'(sa_hb) - 35'({1'b0, sq_root});
        far_n   = -35'(sa_hb) + 35'({1'b0, sq_root});
        a_ext   = DEN_W'(sa_a);
        n0      = (sa_item.shape_kind == SHAPE_PLANE) ? 35'(sa_num) : near_n;
        d0      = (sa_item.shape_kind == SHAPE_PLANE) ? sa_den : a_ext;
        abs_n0  = n0[34] ? -n0 : n0;
        abs_far = far_n[34] ? -far_n : far_n;
        abs_d0  = d0[DEN_W-1] ? -d0 : d0;
        abs_a   = a_ext[DEN_W-1] ? -a_ext : a_ext;
    end

    logic             p_valid_reg, p_miss_reg, p_neg0_reg, p_neg1_reg;
    in_item_t         p_item_reg;
    logic [TNW-1:0]   p_n0_reg, p_n1_reg;
    logic [DEN_W-1:0] p_d0_reg, p_d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (adv)
            p_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_item_reg <= sa_item;
            p_miss_reg <= sa_miss;
            p_neg0_reg <= n0[34] ^ d0[DEN_W-1];
            p_neg1_reg <= far_n[34] ^ a_ext[DEN_W-1];
            p_n0_reg   <= TNW'(abs_n0) << FRAC_BITS;
            p_n1_reg   <= TNW'(abs_far) << FRAC_BITS;
            p_d0_reg   <= abs_d0;
            p_d1_reg   <= abs_a;
        end
    end

    logic           dv0_valid, dv0_neg, dv0_ovf;
    logic           dv1_valid, dv1_neg, dv1_ovf;
    logic [Q_W-1:0] dv0_q, dv1_q;

    rpi_divider #(.NW(TNW), .DW(DEN_W)) u_div_near (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid_reg),
        .in_neg    (p_neg0_reg),
        .in_n      (p_n0_reg),
        .in_d      (p_d0_reg),
        .out_valid (dv0_valid),
        .out_neg   (dv0_neg),
        .out_ovf   (dv0_ovf),
        .out_q     (dv0_q)
    );

    rpi_divider #(.NW(TNW), .DW(DEN_W)) u_div_far (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid_reg),
        .in_neg    (p_neg1_reg),
        .in_n      (p_n1_reg),
        .in_d      (p_d1_reg),
        .out_valid (dv1_valid),
        .out_neg   (dv1_neg),
        .out_ovf   (dv1_ovf),
        .out_q     (dv1_q)
    );

    logic [SB_W-1:0] sb_out;
    in_item_t        sb_item;
    logic            sb_miss;

    assign {sb_item, sb_miss} = sb_out;

    rpi_delay #(.W(SB_W), .N(DIV_LAT)) u_dly_b (
        .clk  (clk),
        .adv  (adv),
        .din  ({p_item_reg, p_miss_reg}),
        .dout (sb_out)
    );

    // root choice and range check
    logic           near_low, use_far, t_neg, t_ovf, t_ok;
    logic [Q_W-1:0] t_q;

    always_comb
    begin
        near_low = dv0_neg || (!dv0_ovf && (dv0_q < t_min_reg));
        use_far  = (sb_item.shape_kind == SHAPE_SPHERE) && near_low;
        t_neg    = use_far ? dv1_neg : dv0_neg;
        t_ovf    = use_far ? dv1_ovf : dv0_ovf;
        t_q      = use_far ? dv1_q : dv0_q;
        t_ok     = !sb_miss && !t_neg && !t_ovf && (t_q >= t_min_reg) && (t_q <= sb_item.t_max);
    end

    logic           t_valid_reg, t_hit_reg;
    in_item_t       t_item_reg;
    logic [Q_W-1:0] t_q_reg;

    // hit point: floored t*dir, then origin + that
    logic signed [63:0] hm [3];
    logic signed [31:0] t_dir [3];

    assign t_dir[0] = t_item_reg.dir_x;
    assign t_dir[1] = t_item_reg.dir_y;
    assign t_dir[2] = t_item_reg.dir_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            hm[i] = 64'($signed({1'b0, t_q_reg})) * 64'(t_dir[i]);
    end

    logic                 h1_valid_reg, h1_hit_reg;
    in_item_t             h1_item_reg;
    logic [Q_W-1:0]       h1_q_reg;
    logic signed [PW-1:0] h1_prod_reg [3];

    logic signed [31:0] h1_org [3];
    assign h1_org[0] = h1_item_reg.origin_x;
    assign h1_org[1] = h1_item_reg.origin_y;
    assign h1_org[2] = h1_item_reg.origin_z;

    logic               h2_valid_reg, h2_hit_reg;
    in_item_t           h2_item_reg;
    logic [Q_W-1:0]     h2_q_reg;
    logic signed [31:0] h2_pt_reg [3];

    // sphere normal operands: (hit - center) / radius
    logic signed [31:0] h2_ctr [3];
    logic signed [32:0] ndiff [3];
    logic [32:0]        nabs [3];
    logic [31:0]        rabs;

    assign h2_ctr[0] = h2_item_reg.prim_x;
    assign h2_ctr[1] = h2_item_reg.prim_y;
    assign h2_ctr[2] = h2_item_reg.prim_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ndiff[i] = 33'(h2_pt_reg[i]) - 33'(h2_ctr[i]);
            nabs[i]  = ndiff[i][32] ? -ndiff[i] : ndiff[i];
        end
        rabs = h2_item_reg.prim_scalar[31] ? -h2_item_reg.prim_scalar
                                           : h2_item_reg.prim_scalar;
    end

    logic               h3_valid_reg, h3_hit_reg;
    in_item_t           h3_item_reg;
    logic [Q_W-1:0]     h3_q_reg;
    logic signed [31:0] h3_pt_reg  [3];
    logic               h3_neg_reg [3];
    logic [NNW-1:0]     h3_n_reg   [3];
    logic [31:0]        h3_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg  <= 1'b0;
            h1_valid_reg <= 1'b0;
            h2_valid_reg <= 1'b0;
            h3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_valid_reg  <= dv0_valid;
            h1_valid_reg <= t_valid_reg;
            h2_valid_reg <= h1_valid_reg;
            h3_valid_reg <= h2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_item_reg <= sb_item;
            t_hit_reg  <= t_ok;
            t_q_reg    <= t_q;

            h1_item_reg <= t_item_reg;
            h1_hit_reg  <= t_hit_reg;
            h1_q_reg    <= t_q_reg;
            for (int i = 0; i < 3; i++)
                h1_prod_reg[i] <= hm[i][63:FRAC_BITS];

            h2_item_reg <= h1_item_reg;
            h2_hit_reg  <= h1_hit_reg;
            h2_q_reg    <= h1_q_reg;
            for (int i = 0; i < 3; i++)
                h2_pt_reg[i] <= sat32(SAT_W'(h1_org[i]) + SAT_W'(h1_prod_reg[i]));

            h3_item_reg <= h2_item_reg;
            h3_hit_reg  <= h2_hit_reg;
            h3_q_reg    <= h2_q_reg;
            h3_r_reg    <= rabs;
            for (int i = 0; i < 3; i++)
            begin
                h3_pt_reg[i]  <= h2_pt_reg[i];
                h3_neg_reg[i] <= ndiff[i][32] ^ h2_item_reg.prim_scalar[31];
                h3_n_reg[i]   <= NNW'(nabs[i]) << FRAC_BITS;
            end
        end
    end

    logic           nd_valid [3];
    logic           nd_neg   [3];
    logic           nd_ovf   [3];
    logic [Q_W-1:0] nd_q     [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_ndiv
        rpi_divider #(.NW(NNW), .DW(32)) u_div_nrm (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (h3_valid_reg),
            .in_neg    (h3_neg_reg[i]),
            .in_n      (h3_n_reg[i]),
            .in_d      (h3_r_reg),
            .out_valid (nd_valid[i]),
            .out_neg   (nd_neg[i]),
            .out_ovf   (nd_ovf[i]),
            .out_q     (nd_q[i])
        );
    end

    logic [SC_W-1:0]    sc_out;
    in_item_t           sc_item;
    logic               sc_hit;
    logic [Q_W-1:0]     sc_q;
    logic signed [31:0] sc_px, sc_py, sc_pz;

    assign {sc_item, sc_hit, sc_q, sc_px, sc_py, sc_pz} = sc_out;

    rpi_delay #(.W(SC_W), .N(DIV_LAT)) u_dly_c (
        .clk  (clk),
        .adv  (adv),
        .din  ({h3_item_reg, h3_hit_reg, h3_q_reg, h3_pt_reg[0], h3_pt_reg[1], h3_pt_reg[2]}),
        .dout (sc_out)
    );

    // result assembly
    out_item_t fin_next;

    always_comb
    begin
        logic plane;
        plane = sc_item.shape_kind == SHAPE_PLANE;
        fin_next = '0;
        if (sc_hit)
        begin
            fin_next.hit      = 1'b1;
            fin_next.distance = sc_q;
            fin_next.hit_x    = sc_px;
            fin_next.hit_y    = sc_py;
            fin_next.hit_z    = sc_pz;
            fin_next.normal_x = plane ? sc_item.prim_x : sat_quot(nd_neg[0], nd_ovf[0], nd_q[0]);
            fin_next.normal_y = plane ? sc_item.prim_y : sat_quot(nd_neg[1], nd_ovf[1], nd_q[1]);
            fin_next.normal_z = plane ? sc_item.prim_z : sat_quot(nd_neg[2], nd_ovf[2], nd_q[2]);
        end
    end

    logic      fin_valid_reg;
    out_item_t fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (adv)
            fin_valid_reg <= nd_valid[0] && nd_valid[1] && nd_valid[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fin_reg <= fin_next;
    end

    // output register plus skid entry
    logic      out_valid_reg;
    out_item_t out_reg, skid_reg;
    logic      incoming;

    assign incoming = adv && fin_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (incoming)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= incoming;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (incoming)
                skid_reg <= fin_reg;
        end
        else if (skid_valid_reg)
            out_reg <= skid_reg;
        else if (incoming)
            out_reg <= fin_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> bench/tb_ray_primitive_intersect.sv
// Testbench for ray_primitive_intersect: directed table plus random rays, checked in order.
// Depends on rpi_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_ray_primitive_intersect;
    import rpi_pkg::*;

    localparam longint ONE = 64'sd1 << 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_DENOM_EPS + 4'd1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 130;
    localparam int IN_W = $bits(in_item_t);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    ray_primitive_intersect u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow registers
    longint t_min_reg = 7;
    longint eps_reg = 1;

    out_item_t pending_hits[$];
    int errors = 0;
    int n_hits = 0;
    int n_miss = 0;
    int n_sphere = 0;
    int n_plane = 0;
    int idle_cycles = 0;
    bit stall_rx = 1'b1;
    bit stall_tx = 1'b1;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fl(longint v);
        return v >>> 16;
    endfunction

    function automatic longint dot3(longint u0, longint u1, longint u2,
                                    longint v0, longint v1, longint v2);
        return fl(u0 * v0) + fl(u1 * v1) + fl(u2 * v2);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic out_item_t predict(in_item_t x);
        longint p[3];
        longint o[3];
        longint d[3];
        longint oc[3];
        longint h[3];
        longint n[3];
        longint sc, a, hb, c, disc, s, t, den, aden, num, tmax;
        out_item_t r;
        r = '0;
        p[0] = x.prim_x;   p[1] = x.prim_y;   p[2] = x.prim_z;
        o[0] = x.origin_x; o[1] = x.origin_y; o[2] = x.origin_z;
        d[0] = x.dir_x;    d[1] = x.dir_y;    d[2] = x.dir_z;
        sc = x.prim_scalar;
        tmax = longint'(x.t_max);
        if (x.shape_kind == SHAPE_SPHERE)
        begin
            for (int i = 0; i < 3; i++)
                oc[i] = clamp32(o[i] - p[i]);
            a = clamp32(dot3(d[0], d[1], d[2], d[0], d[1], d[2]));
            hb = clamp32(dot3(d[0], d[1], d[2], oc[0], oc[1], oc[2]));
            c = clamp32(dot3(oc[0], oc[1], oc[2], oc[0], oc[1], oc[2]) - fl(sc * sc));
            if (sc == 0 || a <= 0)
                return r;
            disc = hb * hb - a * c;
            if (disc < 0)
                return r;
            s = root_floor(disc);
            t = ((-hb - s) * ONE) / a;
            if (t < t_min_reg)
                t = ((-hb + s) * ONE) / a;
            if (t < t_min_reg || t > tmax)
                return r;
            for (int i = 0; i < 3; i++)
            begin
                h[i] = clamp32(o[i] + fl(t * d[i]));
                n[i] = clamp32(((h[i] - p[i]) * ONE) / sc);
            end
        end
        else
        begin
            den = dot3(d[0], d[1], d[2], p[0], p[1], p[2]);
            aden = den < 0 ? -den : den;
            if (den == 0 || aden < eps_reg)
                return r;
            num = clamp32(sc - dot3(o[0], o[1], o[2], p[0], p[1], p[2]));
            t = (num * ONE) / den;
            if (t < t_min_reg || t > tmax)
                return r;
            for (int i = 0; i < 3; i++)
            begin
                h[i] = clamp32(o[i] + fl(t * d[i]));
                n[i] = p[i];
            end
        end
        r.hit = 1'b1;
        r.distance = t[30:0];
        r.hit_x = h[0][31:0];    r.hit_y = h[1][31:0];    r.hit_z = h[2][31:0];
        r.normal_x = n[0][31:0]; r.normal_y = n[1][31:0]; r.normal_z = n[2][31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return 0;
        if (k < 95)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic signed [31:0] srand(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic in_item_t ray(logic kind, int px, int py, int pz, int ps,
                                     int ox, int oy, int oz, int dx, int dy, int dz,
                                     logic [30:0] tmax);
        in_item_t x;
        x.shape_kind = kind;
        x.prim_x = px;   x.prim_y = py;   x.prim_z = pz;   x.prim_scalar = ps;
        x.origin_x = ox; x.origin_y = oy; x.origin_z = oz;
        x.dir_x = dx;    x.dir_y = dy;    x.dir_z = dz;
        x.t_max = tmax;
        return x;
    endfunction

    function automatic in_item_t random_ray();
        in_item_t x;
        int k;
        k = $urandom_range(0, 99);
        if (k < 25)
        begin
            x = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return x;
        end
        x.shape_kind = 1'($urandom_range(0, 1));
        x.origin_x = srand(8 << 16);
        x.origin_y = srand(8 << 16);
        x.origin_z = srand(8 << 16);
        if (x.shape_kind == SHAPE_SPHERE)
        begin
            x.prim_x = srand(8 << 16);
            x.prim_y = srand(8 << 16);
            x.prim_z = srand(8 << 16);
            x.prim_scalar = $urandom_range(1 << 14, 6 << 16);
            if ($urandom_range(0, 9) == 0)
                x.prim_scalar = -x.prim_scalar;
            // aim roughly at the center so most rays hit
            x.dir_x = ((x.prim_x - x.origin_x) >>> $urandom_range(2, 4)) + srand(1 << 14);
            x.dir_y = ((x.prim_y - x.origin_y) >>> $urandom_range(2, 4)) + srand(1 << 14);
            x.dir_z = ((x.prim_z - x.origin_z) >>> $urandom_range(2, 4)) + srand(1 << 14);
        end
        else
        begin
            x.prim_x = srand(1 << 16);
            x.prim_y = srand(1 << 16);
            x.prim_z = srand(1 << 16);
            x.prim_scalar = srand(8 << 16);
            x.dir_x = srand(2 << 16);
            x.dir_y = srand(2 << 16);
            x.dir_z = srand(2 << 16);
        end
        x.t_max = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 40 << 16))
                                              : 31'h7FFFFFFF;
        return x;
    endfunction

    task automatic settle();
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_T_MIN)
            t_min_reg = value[30:0];
        else if (idx == REG_DENOM_EPS)
            eps_reg = value[15:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one transfer; the expected result is taken from the table when given
    task automatic send(in_item_t x, bit use_given, out_item_t given);
        int gap;
        in_valid <= 1'b1;
        in_data <= x;
        do
            @(posedge clk);
        while (!in_ready);
        pending_hits.push_back(use_given ? given : predict(x));
        if (x.shape_kind == SHAPE_SPHERE)
            n_sphere++;
        else
            n_plane++;
        gap = stall_tx ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send(random_ray(), 1'b0, '0);
        in_valid <= 1'b0;
        settle();
    endtask

    always @(posedge clk)
    begin
        if (stall_rx)
            out_ready <= ($urandom_range(0, 99) < 70) ||
                         (!out_ready && $urandom_range(0, 99) < 30);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: %p", out_data);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (out_data.hit !== want.hit || out_data.distance !== want.distance ||
                    out_data.hit_x !== want.hit_x || out_data.hit_y !== want.hit_y ||
                    out_data.hit_z !== want.hit_z || out_data.normal_x !== want.normal_x ||
                    out_data.normal_y !== want.normal_y || out_data.normal_z !== want.normal_z)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at %0t\n  exp %p\n  got %p", $realtime, want, out_data);
                end
                if (want.hit)
                    n_hits++;
                else
                    n_miss++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        in_item_t dir_rows[$];
        bit dir_given[$];
        int one_i;
        int big;
        one_i = 1 << 16;
        big = 32'h7FFFFFFF;

        // directed rows; given = 1 means a miss with all-zero result
        dir_rows.push_back(ray(SHAPE_SPHERE, 0, 0, 5*one_i, one_i, 0, 0, 0, 0, 0, one_i,
                               31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_SPHERE, 0, 0, 5*one_i, 0, 0, 0, 0, 0, 0, one_i,
                               31'h7FFFFFFF));
        dir_given.push_back(1);
        dir_rows.push_back(ray(SHAPE_SPHERE, 0, 0, 5*one_i, one_i, 0, 0, 0, 0, 0, 0,
                               31'h7FFFFFFF));
        dir_given.push_back(1);
        dir_rows.push_back(ray(SHAPE_SPHERE, 5*one_i, 0, 5*one_i, one_i, 0, 0, 0, 0, 0, one_i,
                               31'h7FFFFFFF));
        dir_given.push_back(1);
        // origin inside: far root
        dir_rows.push_back(ray(SHAPE_SPHERE, 0, 0, 0, 3*one_i, 0, 0, 0, one_i, 0, 0,
                               31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_SPHERE, 0, 0, 5*one_i, -one_i, 0, 0, 0, 0, 0, one_i,
                               31'h7FFFFFFF));
        dir_given.push_back(0);
        // sphere behind the ray
        dir_rows.push_back(ray(SHAPE_SPHERE, 0, 0, -5*one_i, one_i, 0, 0, 0, 0, 0, one_i,
                               31'h7FFFFFFF));
        dir_given.push_back(1);
        dir_rows.push_back(ray(SHAPE_SPHERE, 0, 0, 5*one_i, one_i, 0, 0, 0, 0, 0, one_i,
                               31'd0));
        dir_given.push_back(1);
        dir_rows.push_back(ray(SHAPE_PLANE, 0, one_i, 0, 0, 0, 5*one_i, 0, one_i, 0, 0,
                               31'h7FFFFFFF));
        dir_given.push_back(1);
        dir_rows.push_back(ray(SHAPE_PLANE, 0, one_i, 0, 0, 0, 5*one_i, 0, 0, -one_i, 0,
                               31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_PLANE, 0, one_i, 0, 0, 0, 5*one_i, 0, 0, one_i, 0,
                               31'h7FFFFFFF));
        dir_given.push_back(1);
        // smallest nonzero denominator
        dir_rows.push_back(ray(SHAPE_PLANE, 0, one_i, 0, 0, 0, 1, 0, 0, -1, 0, 31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_PLANE, one_i, one_i, one_i, 3*one_i, 0, 0, 0,
                               one_i, one_i, one_i, 31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_SPHERE, big, big, big, big, big, big, big, big, big, big,
                               31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_SPHERE, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, big, big, big, 32'h80000000, 32'h80000000,
                               32'h80000000, 31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_PLANE, 32'h80000000, big, 32'h80000000, big,
                               big, 32'h80000000, big, big, big, 32'h80000000, 31'h7FFFFFFF));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_PLANE, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                               32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                               32'h55555555, 32'hAAAAAAAA, 32'h55555555, 31'h2AAAAAAA));
        dir_given.push_back(0);
        dir_rows.push_back(ray(SHAPE_SPHERE, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                               32'h55555555, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                               32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 31'h55555555));
        dir_given.push_back(0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < dir_rows.size(); i++)
            send(dir_rows[i], dir_given[i], '0);
        in_valid <= 1'b0;
        settle();
        random_phase(140);

        write_reg(REG_T_MIN, 32'd0);
        write_reg(REG_DENOM_EPS, 32'd0);
        write_reg(REG_UNUSED, $urandom);
        random_phase(150);

        // t_min at its top: only a distance of 0x7FFFFFFF can be accepted
        write_reg(REG_T_MIN, 32'h7FFFFFFF);
        write_reg(REG_DENOM_EPS, 32'h0000FFFF);
        random_phase(50);

        write_reg(REG_T_MIN, $urandom_range(0, 2 << 16));
        write_reg(REG_DENOM_EPS, $urandom);
        random_phase(150);

        stall_rx = 1'b0;
        stall_tx = 1'b0;
        write_reg(REG_T_MIN, 32'd7);
        write_reg(REG_DENOM_EPS, 32'd1);
        random_phase(140);

        $display("covered %0d sphere and %0d plane rays over five register settings",
                 n_sphere, n_plane);
        $display("results checked: %0d hits, %0d misses, %0d errors", n_hits, n_miss, errors);
        if (errors == 0 && pending_hits.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> ray_primitive_intersect.f
design/rpi_pkg.sv
design/rpi_delay.sv
design/rpi_sqrt.sv
design/rpi_divider.sv
design/rpi_front.sv
design/ray_primitive_intersect.sv
bench/tb_ray_primitive_intersect.sv
